// File: sv/lqe_pkg.sv
// Shared types, codes and constants of the link quality estimator.
package lqe_pkg;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int LOOP_LEN_DEF   = 50;
   localparam int CFG_W          = 7;
   localparam int DIV_W          = 16;
   localparam int RATIO_CAP      = 99;
   localparam int PERCENT        = 100;

   localparam logic [2:0] REQ_SAMPLE = 3'd0;
   localparam logic [2:0] REQ_TICK   = 3'd1;
   localparam logic [2:0] REQ_RECV   = 3'd2;
   localparam logic [2:0] REQ_CONF   = 3'd3;
   localparam logic [2:0] REQ_CLEAR  = 3'd4;

   localparam logic [1:0] CSR_WINDOW_LEN    = 2'd0;
   localparam logic [1:0] CSR_RISING_FACTOR = 2'd1;
   localparam logic [1:0] CSR_USE_RATIO     = 2'd2;
   localparam logic [1:0] CSR_FULL_SCALE    = 2'd3;

   typedef enum logic [2:0] {
      OP_SAMPLE,
      OP_TICK,
      OP_RECV,
      OP_CONF,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [7:0]  sample;
      logic [31:0]        loop_id;
   } cmd_type;

   typedef struct packed {
      logic [CFG_W-1:0] window_len;
      logic [CFG_W-1:0] rising_factor;
      logic             use_delivery_ratio;
      logic [CFG_W-1:0] rssi_full_scale;
   } cfg_type;

endpackage

// File: sv/lqe_ram.sv
// Generic single-port-write, registered-read RAM.
module lqe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/lqe_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module lqe_div #(
   parameter int W = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W);

   logic         busy_ff;
   logic         done_ff;
   logic [CW-1:0] cnt_ff;
   logic [W-1:0] rem_ff;
   logic [W-1:0] quo_ff;
   logic [W-1:0] dvs_ff;
   logic [W:0]   shifted;
   logic [W:0]   trial;

   assign shifted = {rem_ff, quo_ff[W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= !start && busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W - 1);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            if (!trial[W]) begin
               rem_ff <= trial[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[W-1:0];
               quo_ff <= {quo_ff[W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/lqe_front.sv
// Front end: accepts request items, classifies them and queues commands.
module lqe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [15:0] req_sample_value,
   input  logic [31:0]        req_loop_id,
   output logic               cmd_valid,
   output lqe_pkg::cmd_type   cmd,
   input  logic               cmd_pop
);

   import lqe_pkg::*;

   cmd_type    cmd_in;
   cmd_type    queue_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;

   always_comb begin
      cmd_in.sample  = req_sample_value[7:0];
      cmd_in.loop_id = req_loop_id;
      case (req_type)
         REQ_SAMPLE: cmd_in.op = OP_SAMPLE;
         REQ_TICK:   cmd_in.op = OP_TICK;
         REQ_RECV:   cmd_in.op = OP_RECV;
         // Only a negative confidence value has any effect.
         REQ_CONF:   cmd_in.op = req_sample_value[15] ? OP_CONF : OP_NONE;
         REQ_CLEAR:  cmd_in.op = OP_CLEAR;
         default:    cmd_in.op = OP_NONE;
      endcase
   end

   assign req_stall = reset || (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, cmd_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: sv/lqe_back.sv
// Back end: executes queued commands on the sample ring and the loop window.
module lqe_back #(
   parameter int WINDOW_MAX = lqe_pkg::WINDOW_MAX_DEF,
   parameter int LOOP_LEN   = lqe_pkg::LOOP_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lqe_pkg::cfg_type  cfg,
   input  logic              cmd_valid,
   input  lqe_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_quality,
   output logic signed [7:0] rsp_avg_signal,
   output logic [6:0]        rsp_delivery_ratio
);

   import lqe_pkg::*;

   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int NW    = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = AW + 8;
   localparam int LIW   = $clog2(LOOP_LEN);
   localparam int CNTW  = $clog2(LOOP_LEN + 1);
   localparam int EW    = (NW > CFG_W) ? NW : CFG_W;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PDIV,
      S_FILL,
      S_WRITE,
      S_SUM,
      S_ASTART,
      S_ADIV,
      S_RSTART,
      S_QUAL,
      S_QDIV,
      S_OUT
   } state_type;

   function automatic logic [6:0] ratio_of(input int count);
      int r;
      r = count * PERCENT / LOOP_LEN;
      return (r > RATIO_CAP) ? 7'(RATIO_CAP) : 7'(r);
   endfunction

   state_type               state_ff;
   cmd_type                 cmd_ff;
   logic                    primed_ff;
   logic signed [7:0]       avg_ff;
   logic [NW-1:0]           wi_ff;
   logic [NW-1:0]           end_ff;
   logic [NW-1:0]           idx_ff;
   logic                    pend_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [LOOP_LEN-1:0]     bits_ff;
   logic [LIW-1:0]          lidx_ff;
   logic [CNTW-1:0]         cnt_ff;
   logic [6:0]              ratio_ff;
   logic [31:0]             last_ff;
   logic signed [7:0]       qual_ff;
   logic                    neg_ff;
   logic                    div_run_ff;
   logic [DIV_W-1:0]        div_a_ff;
   logic [DIV_W-1:0]        div_b_ff;
   logic                    rsp_valid_ff;
   logic signed [7:0]       rsp_quality_ff;
   logic signed [7:0]       rsp_avg_signal_ff;
   logic [6:0]              rsp_delivery_ratio_ff;

   logic [EW-1:0]           wl;
   logic [NW-1:0]           n_eff;
   logic [CFG_W-1:0]        f_eff;
   logic [CFG_W-1:0]        fs_eff;
   logic [NW-1:0]           wi_in;
   logic [LIW-1:0]          lidx_in;
   logic [7:0]              avg_mag;
   logic [SUM_W-1:0]        sum_mag;
   logic                    div_start;
   logic                    div_done;
   logic [DIV_W-1:0]        div_quo;
   logic                    ram_we;
   logic [AW-1:0]           ram_wa;
   logic [7:0]              ram_wd;
   logic [7:0]              ram_rd;
   logic [6:0]              ratio_lut [LOOP_LEN+1];

   // The delivery ratio depends only on the count of set bits, so it comes from a fixed table.
   for (genvar g = 0; g <= LOOP_LEN; g++) begin : g_ratio
      assign ratio_lut[g] = ratio_of(g);
   end

   always_comb begin
      wl = EW'(cfg.window_len);
      if (wl == '0) begin
         n_eff = NW'(1);
      end else if (wl > EW'(WINDOW_MAX)) begin
         n_eff = NW'(WINDOW_MAX);
      end else begin
         n_eff = NW'(wl);
      end
      f_eff   = (cfg.rising_factor == '0) ? CFG_W'(1) : cfg.rising_factor;
      fs_eff  = (cfg.rssi_full_scale == '0) ? CFG_W'(1) : cfg.rssi_full_scale;
      wi_in   = ((wi_ff + 1'b1) >= n_eff) ? '0 : wi_ff + 1'b1;
      lidx_in = (lidx_ff == LIW'(LOOP_LEN - 1)) ? '0 : lidx_ff + 1'b1;
      avg_mag = avg_ff[7] ? 8'(-avg_ff) : avg_ff;
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   end

   // The divider is started in the first cycle of each division state.
   assign div_start = (state_ff inside {S_PDIV, S_ADIV, S_QDIV}) && !div_run_ff;

   // The prefill sweep writes every entry; otherwise the new sample is written once.
   always_comb begin
      ram_we = 1'b0;
      ram_wa = wi_ff[AW-1:0];
      ram_wd = cmd_ff.sample;
      if (state_ff == S_FILL) begin
         ram_we = 1'b1;
         ram_wa = idx_ff[AW-1:0];
         ram_wd = (idx_ff < end_ff) ? cmd_ff.sample : 8'd0;
      end else if (state_ff == S_WRITE) begin
         ram_we = 1'b1;
      end
   end

   lqe_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   lqe_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         avg_ff       <= '0;
         wi_ff        <= '0;
         bits_ff      <= '1;
         lidx_ff      <= '0;
         cnt_ff       <= CNTW'(LOOP_LEN);
         ratio_ff     <= '0;
         last_ff      <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         div_run_ff <= (state_ff inside {S_PDIV, S_ADIV, S_QDIV});
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd;
                  case (cmd.op)
                     OP_SAMPLE: begin
                        if (!primed_ff) begin
                           div_a_ff <= DIV_W'(n_eff);
                           div_b_ff <= DIV_W'(f_eff);
                           state_ff <= S_PDIV;
                        end else begin
                           wi_ff    <= wi_in;
                           state_ff <= S_WRITE;
                        end
                     end
                     OP_TICK: begin
                        if (cmd.loop_id != last_ff) begin
                           lidx_ff          <= lidx_in;
                           bits_ff[lidx_in] <= 1'b0;
                           if (bits_ff[lidx_in]) begin
                              cnt_ff <= cnt_ff - 1'b1;
                           end
                           last_ff  <= cmd.loop_id;
                           state_ff <= S_RSTART;
                        end else begin
                           state_ff <= S_QUAL;
                        end
                     end
                     OP_RECV: begin
                        bits_ff[lidx_ff] <= 1'b1;
                        if (!bits_ff[lidx_ff]) begin
                           cnt_ff <= cnt_ff + 1'b1;
                        end
                        state_ff <= S_RSTART;
                     end
                     OP_CONF: begin
                        // Clearing the lowest set bit is a mask with the value minus one.
                        if (bits_ff != '0) begin
                           bits_ff <= bits_ff & (bits_ff - 1'b1);
                           cnt_ff  <= cnt_ff - 1'b1;
                        end
                        state_ff <= S_RSTART;
                     end
                     OP_CLEAR: begin
                        primed_ff <= 1'b0;
                        avg_ff    <= '0;
                        state_ff  <= S_QUAL;
                     end
                     default: state_ff <= S_QUAL;
                  endcase
               end
            end
            S_PDIV: begin
               if (div_done) begin
                  end_ff   <= NW'(div_quo);
                  idx_ff   <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_FILL;
               end
            end
            S_FILL: begin
               if (idx_ff < end_ff) begin
                  sum_ff <= sum_ff + {{(SUM_W-8){cmd_ff.sample[7]}}, cmd_ff.sample};
               end
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == NW'(WINDOW_MAX - 1)) begin
                  wi_ff     <= end_ff;
                  primed_ff <= 1'b1;
                  state_ff  <= S_ASTART;
               end
            end
            S_WRITE: begin
               idx_ff   <= '0;
               pend_ff  <= 1'b0;
               sum_ff   <= '0;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               // Read data arrives in the cycle after its address.
               if (idx_ff < n_eff) begin
                  idx_ff  <= idx_ff + 1'b1;
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  sum_ff <= sum_ff + {{(SUM_W-8){ram_rd[7]}}, ram_rd};
               end
               if (idx_ff == n_eff && !pend_ff) begin
                  state_ff <= S_ASTART;
               end
            end
            S_ASTART: begin
               div_a_ff <= DIV_W'(sum_mag);
               div_b_ff <= DIV_W'(n_eff);
               neg_ff   <= sum_ff[SUM_W-1];
               state_ff <= S_ADIV;
            end
            S_ADIV: begin
               if (div_done) begin
                  avg_ff   <= neg_ff ? 8'(-div_quo[7:0]) : div_quo[7:0];
                  state_ff <= S_QUAL;
               end
            end
            S_RSTART: begin
               ratio_ff <= ratio_lut[cnt_ff];
               state_ff <= S_QUAL;
            end
            S_QUAL: begin
               if (cfg.use_delivery_ratio) begin
                  qual_ff  <= {1'b0, ratio_ff};
                  state_ff <= S_OUT;
               end else if ($signed({avg_ff[7], avg_ff}) > $signed({2'b00, fs_eff})) begin
                  qual_ff  <= 8'(RATIO_CAP);
                  state_ff <= S_OUT;
               end else begin
                  div_a_ff <= DIV_W'(avg_mag) * DIV_W'(RATIO_CAP);
                  div_b_ff <= DIV_W'(fs_eff);
                  neg_ff   <= avg_ff[7];
                  state_ff <= S_QDIV;
               end
            end
            S_QDIV: begin
               if (div_done) begin
                  if (neg_ff) begin
                     qual_ff <= (div_quo > DIV_W'(128)) ? -8'sd128 : 8'(-div_quo[7:0]);
                  end else begin
                     qual_ff <= (div_quo > DIV_W'(RATIO_CAP)) ? 8'(RATIO_CAP) : div_quo[7:0];
                  end
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_quality_ff        <= qual_ff;
                  rsp_avg_signal_ff     <= avg_ff;
                  rsp_delivery_ratio_ff <= ratio_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quality        = rsp_quality_ff;
   assign rsp_avg_signal     = rsp_avg_signal_ff;
   assign rsp_delivery_ratio = rsp_delivery_ratio_ff;

endmodule

// File: sv/link_quality_estimator_core.sv
// Top level of the link quality estimator: configuration registers and the two halves.
//
// Request items (req_) carry a type code, a signal or confidence value and a loop id.
// Every accepted item yields exactly one result item on rsp_: the link quality, the
// averaged signal strength and the loop delivery ratio, in request order.
// Configuration (csr_) is a plain write port, to be used only while the block is idle.
// A two-entry command queue sits between the front end and the back end, so requests
// are taken while the back end is busy or a result is waiting.
// The work per item depends on its kind: loop events, confidence values and resets of
// the average need at most one division; a signal sample also sums an n-entry window
// through the single read port of the sample ring, and the first sample after reset or
// a clear first sweeps the whole ring. All divisions use one shared divider.
// Items are processed one at a time: the back end takes no new command until the
// result of the previous one has been loaded into the rsp_ outputs.
// Reset empties the queue, drops any pending result and restores register defaults.
// While the receiver stalls, the result holds and the back end waits once it has
// another one ready; the queue then fills and req_stall rises.
module link_quality_estimator_core #(
   parameter int WINDOW_MAX = lqe_pkg::WINDOW_MAX_DEF,
   parameter int LOOP_LEN   = lqe_pkg::LOOP_LEN_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_type,
   input  logic signed [15:0]       req_sample_value,
   input  logic [31:0]              req_loop_id,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [7:0]        rsp_quality,
   output logic signed [7:0]        rsp_avg_signal,
   output logic [6:0]               rsp_delivery_ratio,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [lqe_pkg::CFG_W-1:0] csr_wdata
);

   import lqe_pkg::*;

   cfg_type cfg_ff;
   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_len         <= CFG_W'(16);
         cfg_ff.rising_factor      <= CFG_W'(1);
         cfg_ff.use_delivery_ratio <= 1'b0;
         cfg_ff.rssi_full_scale    <= CFG_W'(60);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_WINDOW_LEN:    cfg_ff.window_len         <= csr_wdata;
            CSR_RISING_FACTOR: cfg_ff.rising_factor      <= csr_wdata;
            CSR_USE_RATIO:     cfg_ff.use_delivery_ratio <= csr_wdata[0];
            CSR_FULL_SCALE:    cfg_ff.rssi_full_scale    <= csr_wdata;
            default:           cfg_ff                    <= cfg_ff;
         endcase
      end
   end

   lqe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_sample_value (req_sample_value),
      .req_loop_id      (req_loop_id),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   lqe_back #(
      .WINDOW_MAX (WINDOW_MAX),
      .LOOP_LEN   (LOOP_LEN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quality        (rsp_quality),
      .rsp_avg_signal     (rsp_avg_signal),
      .rsp_delivery_ratio (rsp_delivery_ratio)
   );

   // No result may be shown straight after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The back end only takes a command that the queue actually holds.
   a_pop_has_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");

   a_ratio_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_delivery_ratio <= 7'd99)
      else $error("delivery ratio above cap");

   a_quality_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_quality <= 8'sd99)
      else $error("quality above cap");

endmodule

// File: dv/link_quality_estimator_core_tb.sv
// Self-checking testbench for the link quality estimator core.
`timescale 1ns / 1ps

module link_quality_estimator_core_tb;
   import lqe_pkg::*;

   typedef struct {
      logic signed [7:0] quality;
      logic signed [7:0] avg_signal;
      logic [6:0]        delivery_ratio;
   } lq_report;

   class link_quality_predictor;
      logic [6:0]        window_len;
      logic [6:0]        rising_factor;
      logic              use_ratio;
      logic [6:0]        full_scale;
      logic signed [7:0] ring [WINDOW_MAX_DEF];
      int                wr_idx;
      bit                primed;
      int                avg;
      bit [LOOP_LEN_DEF-1:0] loop_bits;
      int                loop_idx;
      int                ratio;
      logic [31:0]       last_loop;
      lq_report          expected_reports [$];
      int                mismatches;

      function new();
         window_len = 16; rising_factor = 1; use_ratio = 0; full_scale = 60;
         foreach (ring[i]) ring[i] = 0;
         wr_idx = 0; primed = 0; avg = 0;
         loop_bits = '1; loop_idx = 0; ratio = 0; last_loop = 0;
         mismatches = 0;
      endfunction

      function void configure(logic [1:0] idx, logic [6:0] val);
         case (idx)
            CSR_WINDOW_LEN:    window_len = val;
            CSR_RISING_FACTOR: rising_factor = val;
            CSR_USE_RATIO:     use_ratio = val[0];
            CSR_FULL_SCALE:    full_scale = val;
            default: ;
         endcase
      endfunction

      function int active_window();
         if (window_len == 0) return 1;
         if (window_len > WINDOW_MAX_DEF) return WINDOW_MAX_DEF;
         return window_len;
      endfunction

      function void update_ratio();
         int total;
         total = $countones(loop_bits) * PERCENT / LOOP_LEN_DEF;
         ratio = total > RATIO_CAP ? RATIO_CAP : total;
      endfunction

      function int link_quality();
         int fs, q;
         if (use_ratio) return ratio;
         fs = full_scale == 0 ? 1 : full_scale;
         if (avg > fs) return RATIO_CAP;
         q = avg * RATIO_CAP / fs;
         if (q > RATIO_CAP) q = RATIO_CAP;
         if (q < -128) q = -128;
         return q;
      endfunction

      function void note_request(logic [2:0] kind, logic [15:0] value, logic [31:0] id);
         int n, f, fill, total;
         lq_report rep;
         n = active_window();
         case (kind)
            REQ_SAMPLE: begin
               if (!primed) begin
                  // The first sample after reset or a clear clears the ring and prefills its first n / f entries.
                  f = rising_factor == 0 ? 1 : rising_factor;
                  fill = n / f;
                  foreach (ring[i]) ring[i] = (i < fill) ? value[7:0] : 8'sd0;
                  wr_idx = fill;
                  primed = 1;
               end else begin
                  wr_idx++;
                  if (wr_idx >= n) wr_idx = 0;
                  ring[wr_idx] = value[7:0];
               end
               total = 0;
               for (int i = 0; i < n; i++) total += ring[i];
               avg = total / n;
            end
            REQ_TICK: begin
               if (id != last_loop) begin
                  loop_idx++;
                  if (loop_idx >= LOOP_LEN_DEF) loop_idx = 0;
                  loop_bits[loop_idx] = 0;
                  update_ratio();
                  last_loop = id;
               end
            end
            REQ_RECV: begin
               loop_bits[loop_idx] = 1;
               update_ratio();
            end
            REQ_CONF: begin
               if (value[15]) begin
                  for (int i = 0; i < LOOP_LEN_DEF; i++) begin
                     if (loop_bits[i]) begin
                        loop_bits[i] = 0;
                        break;
                     end
                  end
                  update_ratio();
               end
            end
            REQ_CLEAR: begin
               primed = 0;
               avg = 0;
            end
            default: ;
         endcase
         rep.quality = 8'(link_quality());
         rep.avg_signal = 8'(avg);
         rep.delivery_ratio = 7'(ratio);
         expected_reports.push_back(rep);
      endfunction

      function void check_result(logic signed [7:0] q, logic signed [7:0] a, logic [6:0] r);
         lq_report rep;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: quality %0d avg %0d ratio %0d", q, a, r);
            return;
         end
         rep = expected_reports.pop_front();
         if (q !== rep.quality || a !== rep.avg_signal || r !== rep.delivery_ratio) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected quality %0d avg %0d ratio %0d, got %0d %0d %0d",
                        rep.quality, rep.avg_signal, rep.delivery_ratio, q, a, r);
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_type = '0;
   logic signed [15:0] req_sample_value = '0;
   logic [31:0] req_loop_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [7:0] rsp_quality;
   logic signed [7:0] rsp_avg_signal;
   logic [6:0]  rsp_delivery_ratio;
   logic        csr_write_enable = 0;
   logic [1:0]  csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   link_quality_predictor predictor = new();
   int          burst_left = 0;
   logic [31:0] next_loop = 1;
   int          stall_left = 0;
   int          stall_mode = 0;

   always #1 clock = ~clock;

   link_quality_estimator_core dut (.*);

   // The receiver switches between free running, random and mostly stalled stretches.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_result(rsp_quality, rsp_avg_signal, rsp_delivery_ratio);
   end

   // Called at a clock edge; returns at the edge where the item is accepted.
   task automatic send_item(input logic [2:0] kind, input logic [15:0] value,
                            input logic [31:0] id);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample_value <= value;
      req_loop_id <= id;
      do @(posedge clock); while (req_stall);
      predictor.note_request(kind, value, id);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (predictor.pending() != 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      predictor.configure(idx, val);
   endtask

   task automatic send_random();
      int pick;
      logic [31:0] id;
      pick = $urandom_range(0, 99);
      if (pick < 45) send_item(REQ_SAMPLE, 16'($urandom), 32'($urandom));
      else if (pick < 60) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            id = next_loop;
            next_loop = next_loop + 1;
         end else if (pick == 7) id = predictor.last_loop;
         else if (pick == 8) id = $urandom;
         else id = 0;
         send_item(REQ_TICK, 16'($urandom), id);
      end
      else if (pick < 75) send_item(REQ_RECV, 16'($urandom), 32'($urandom));
      else if (pick < 87) send_item(REQ_CONF, 16'($urandom), 32'($urandom));
      else if (pick < 94) send_item(REQ_CLEAR, 16'($urandom), 32'($urandom));
      else send_item(REQ_CLEAR + 3'($urandom_range(1, 3)), 16'($urandom), 32'($urandom));
   endtask

   initial begin
      int win [9]  = '{16, 1, 64, 127, 0, 5, 33, 64, 8};
      int rise [9] = '{1, 1, 64, 1, 0, 2, 3, 127, 7};
      int mode [9] = '{0, 1, 0, 0, 1, 0, 0, 1, 0};
      int fs [9]   = '{60, 1, 127, 0, 30, 127, 5, 60, 99};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(REQ_SAMPLE, 16'h007F, 0);
      send_item(REQ_SAMPLE, 16'hFF80, 0);
      send_item(REQ_SAMPLE, 16'h7FFF, 0);
      send_item(REQ_SAMPLE, 16'h8000, 0);
      send_item(REQ_TICK, 16'h0000, 32'h0000_0000);
      send_item(REQ_TICK, 16'h0000, 32'hFFFF_FFFF);
      send_item(REQ_TICK, 16'h0000, 32'hFFFF_FFFF);
      send_item(REQ_RECV, 16'h0000, 0);
      send_item(REQ_CONF, 16'h8000, 0);
      send_item(REQ_CONF, 16'h7FFF, 0);
      send_item(REQ_CONF, 16'h0000, 0);
      send_item(REQ_CLEAR, 16'h0000, 0);
      send_item(REQ_SAMPLE, 16'h0064, 0);
      send_item(REQ_CLEAR + 3'd1, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(REQ_CLEAR + 3'd2, 16'h0000, 0);
      send_item(REQ_CLEAR + 3'd3, 16'h1234, 32'h5A5A_A5A5);
      send_item(REQ_SAMPLE, 16'hFFCE, 0);

      for (int p = 0; p < 9; p++) begin
         // Every pause before reprogramming also drains the result channel completely.
         wait_idle();
         write_reg(CSR_WINDOW_LEN, 7'(win[p]));
         write_reg(CSR_RISING_FACTOR, 7'(rise[p]));
         write_reg(CSR_USE_RATIO, 7'(mode[p]));
         write_reg(CSR_FULL_SCALE, 7'(fs[p]));
         @(posedge clock);
         send_item(REQ_CLEAR, 16'h0000, 0);
         for (int k = 0; k < 188; k++) send_random();
      end

      wait_idle();
      if (predictor.mismatches == 0 && predictor.pending() == 0)
         $display("link_quality_estimator_core test passed");
      else
         $display("link_quality_estimator_core test failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("link_quality_estimator_core test failed");
      $finish;
   end

endmodule

// File: link_quality_estimator_core.f
sv/lqe_pkg.sv
sv/lqe_ram.sv
sv/lqe_div.sv
sv/lqe_front.sv
sv/lqe_back.sv
sv/link_quality_estimator_core.sv
dv/link_quality_estimator_core_tb.sv
